FILE: design/ucd_pkg.sv
// Shared types and constants for the undirected cycle detector.
// Used by ucd_ctrl, ucd_dpath and undirected_cycle_detect; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ucd_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VW           = 11;  // vertex field width
    localparam int IW           = $clog2(MAX_VERTICES);  // zero-based vertex index
    localparam int EAW          = $clog2(MAX_EDGES);
    localparam int ECW          = EAW + 1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic add;        // store or drop the accepted edge beat
        logic clr_wr;     // clear one parent entry, advance the sweep
        logic eval_start; // rewind the edge index, clear the found flag
        logic edge_rd;    // read the edge at the current index
        logic load_ab;    // take the read edge as the two walk pointers
        logic edge_next;  // advance the edge index
        logic par_rd_a;   // read the parent of pointer a
        logic par_rd_b;   // read the parent of pointer b
        logic step_a;     // follow the parent link of pointer a
        logic step_b;     // follow the parent link of pointer b
        logic unite;      // link root a under root b
        logic set_found;  // a cycle was found
        logic out_load;   // load the result, reset the edge count and drop flag
    } t_cmd;

    typedef struct packed {
        logic clr_last;   // sweep at its last entry
        logic edges_left; // edge index below the edge count
        logic edge_ok;    // read edge has both endpoints within the count
        logic par_root;   // read parent entry marks a root
        logic same_root;  // both pointers on the same vertex
        logic out_busy;   // result register still holds an untaken beat
    } t_status;

endpackage
`default_nettype wire

FILE: design/ucd_dpath.sv
// Datapath of the cycle detector: edge store, union-find parent memory,
// counters and result register. Depends on ucd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ucd_dpath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ucd_pkg::t_cmd           i_cmd,
    output ucd_pkg::t_status             o_status,
    input  wire logic                    i_cfg_we,
    input  wire logic [ucd_pkg::VW-1:0]  i_cfg_data,
    input  wire logic [ucd_pkg::VW-1:0]  i_vertex_a,
    input  wire logic [ucd_pkg::VW-1:0]  i_vertex_b,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_has_cycle,
    output logic                         o_edges_dropped
);
    localparam int VW  = ucd_pkg::VW;
    localparam int IW  = ucd_pkg::IW;
    localparam int EAW = ucd_pkg::EAW;
    localparam int ECW = ucd_pkg::ECW;

    logic [VW-1:0]    r_vcount;
    logic [ECW-1:0]   r_edge_total;
    logic             r_drop;
    logic [ECW-1:0]   r_edge_idx;
    logic [IW-1:0]    r_clr_idx;
    logic [IW-1:0]    r_ra, r_rb;
    logic             r_found;
    logic [2*IW-1:0]  r_edge_q;
    logic [VW-1:0]    r_par_q;
    logic             r_out_valid, r_has_cycle, r_dropped;

    logic [2*IW-1:0]  edge_mem [ucd_pkg::MAX_EDGES];
    logic [VW-1:0]    par_mem  [ucd_pkg::MAX_VERTICES];

    logic [VW-1:0]    vcount_eff;
    logic             add_ok;
    logic [IW-1:0]    qa, qb;

    always_comb begin
        vcount_eff = (r_vcount > VW'(ucd_pkg::MAX_VERTICES)) ?
                     VW'(ucd_pkg::MAX_VERTICES) : r_vcount;
        add_ok = (i_vertex_a != '0) && (i_vertex_a <= vcount_eff) &&
                 (i_vertex_b != '0) && (i_vertex_b <= vcount_eff) &&
                 (r_edge_total != ECW'(ucd_pkg::MAX_EDGES));
        qa = r_edge_q[2*IW-1:IW];
        qb = r_edge_q[IW-1:0];
    end

    // Edge store: written on add, read during the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && add_ok) begin
            edge_mem[r_edge_total[EAW-1:0]] <= {IW'(i_vertex_a - 1'b1),
                                                IW'(i_vertex_b - 1'b1)};
        end
        if (i_cmd.edge_rd) begin
            r_edge_q <= edge_mem[r_edge_idx[EAW-1:0]];
        end
    end

    // Parent memory: zero marks a root, otherwise the parent index plus one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            par_mem[r_clr_idx] <= '0;
        end else if (i_cmd.unite) begin
            par_mem[r_ra] <= VW'(r_rb) + 1'b1;
        end
        if (i_cmd.par_rd_a) begin
            r_par_q <= par_mem[r_ra];
        end else if (i_cmd.par_rd_b) begin
            r_par_q <= par_mem[r_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ab) begin
            r_ra <= qa;
            r_rb <= qb;
        end else begin
            if (i_cmd.step_a) r_ra <= IW'(r_par_q - 1'b1);
            if (i_cmd.step_b) r_rb <= IW'(r_par_q - 1'b1);
        end
        if (i_cmd.out_load) begin
            r_has_cycle <= r_found;
            r_dropped   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount     <= '0;
            r_edge_total <= '0;
            r_drop       <= 1'b0;
            r_edge_idx   <= '0;
            r_clr_idx    <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_data;
            if (i_cmd.add) begin
                if (add_ok) r_edge_total <= r_edge_total + 1'b1;
                else        r_drop       <= 1'b1;
            end
            if (i_cmd.clr_wr) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.eval_start) begin
                r_edge_idx <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.edge_next) begin
                r_edge_idx <= r_edge_idx + 1'b1;
            end
            if (i_cmd.set_found) r_found <= 1'b1;
            if (i_cmd.out_load) begin
                r_edge_total <= '0;
                r_drop       <= 1'b0;
                r_clr_idx    <= '0;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clr_last   = (r_clr_idx == '1);
        o_status.edges_left = (r_edge_idx < r_edge_total);
        o_status.edge_ok    = ({1'b0, qa} < vcount_eff) && ({1'b0, qb} < vcount_eff);
        o_status.par_root   = (r_par_q == '0);
        o_status.same_root  = (r_ra == r_rb);
        o_status.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_cycle     = r_has_cycle;
    assign o_edges_dropped = r_dropped;

endmodule
`default_nettype wire

FILE: design/ucd_ctrl.sv
// Controller of the cycle detector: sequences loading, the union-find walk
// over the stored edges and the parent clearing sweep. Depends on ucd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ucd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_op,
    input  wire ucd_pkg::t_status i_status,
    output ucd_pkg::t_cmd         o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_E_RD, S_E_CHK, S_FA_RD, S_FA_CHK,
        S_FB_RD, S_FB_CHK, S_UNION, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        accept     = o_in_ready && i_in_valid;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && i_op == ucd_pkg::OP_ADD) o_cmd.add = 1'b1;
                if (accept && i_op == ucd_pkg::OP_EVAL) begin
                    o_cmd.eval_start = 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                if (!i_status.edges_left) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = S_E_CHK;
                end
            end
            S_E_CHK: begin
                if (i_status.edge_ok) begin
                    o_cmd.load_ab = 1'b1;
                    n_state = S_FA_RD;
                end else begin
                    o_cmd.edge_next = 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_FA_RD: begin
                o_cmd.par_rd_a = 1'b1;
                n_state = S_FA_CHK;
            end
            S_FA_CHK: begin
                if (i_status.par_root) begin
                    n_state = S_FB_RD;
                end else begin
                    o_cmd.step_a = 1'b1;
                    n_state = S_FA_RD;
                end
            end
            S_FB_RD: begin
                o_cmd.par_rd_b = 1'b1;
                n_state = S_FB_CHK;
            end
            S_FB_CHK: begin
                if (i_status.par_root) begin
                    n_state = S_UNION;
                end else begin
                    o_cmd.step_b = 1'b1;
                    n_state = S_FB_RD;
                end
            end
            S_UNION: begin
                if (i_status.same_root) begin
                    o_cmd.set_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.unite     = 1'b1;
                    o_cmd.edge_next = 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: design/undirected_cycle_detect.sv
// Top level of the undirected cycle detector: ties the controller to the
// datapath. Depends on ucd_pkg, ucd_ctrl and ucd_dpath.
//
// Usage: set vertex_count through i_cfg_we/i_cfg_data while idle. Each input
// beat with op 0 adds the edge (vertex_a, vertex_b); an edge with an endpoint
// of 0 or above the count, or one beyond 4096 stored edges, is dropped and
// flagged. An add beat gives no result, and adds can follow back to back.
// A beat with op 1 evaluates: the stored edges are scanned in order with a
// union-find over a parent memory. An edge with an endpoint above the count
// is read, checked and skipped; for any other, the finds follow the parent
// links of both endpoints to their roots, and differing roots are united.
// The scan stops at the first edge that closes a cycle, or once the edges
// run out; the result beat is loaded once the output register is free,
// and the edge count and drop flag reset. After that the parent memory is
// swept, one entry per cycle over all 1024 entries, during which no input
// beat is taken. The same sweep runs after reset before the first beat is
// accepted. The result waits in its output register while the receiver
// stalls; a second evaluation holds its result until the first beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module undirected_cycle_detect (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [ucd_pkg::VW-1:0] i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_op,
    input  wire logic [ucd_pkg::VW-1:0] i_vertex_a,
    input  wire logic [ucd_pkg::VW-1:0] i_vertex_b,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_has_cycle,
    output logic                        o_edges_dropped
);
    ucd_pkg::t_cmd    cmd;
    ucd_pkg::t_status status;

    ucd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ucd_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_cycle     (o_has_cycle),
        .o_edges_dropped (o_edges_dropped)
    );

endmodule
`default_nettype wire
